@@ hw/rtl/sbp_pkg.sv @@
package sbp_pkg;

  localparam int BYTE_W     = 8;
  localparam int SYM_W      = 8;
  localparam int CFG_W      = 4;
  localparam int FILL_W     = 3;
  localparam int PAD_W      = 3;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_W-1:0] SYM_BITS_RESET = 4'd5;
  localparam logic [CFG_W-1:0] SYM_BITS_MAX   = 4'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              byte_last;
    logic [PAD_W-1:0]  pad_bits;
  } byte_item_t;

  // Up to two bytes leave the packer per symbol; push1 is only set with push0.
  typedef struct packed {
    logic       push0;
    logic       push1;
    byte_item_t item0;
    byte_item_t item1;
  } push_t;

endpackage

@@ hw/rtl/sbp_sym_if.sv @@
interface sbp_sym_if;
  logic                     valid;
  logic                     ready;
  logic [sbp_pkg::SYM_W-1:0] symbol;
  logic                     last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

@@ hw/rtl/sbp_byte_if.sv @@
interface sbp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [sbp_pkg::BYTE_W-1:0] packed_byte;
  logic                      byte_last;
  logic [sbp_pkg::PAD_W-1:0]  pad_bits;

  modport source (output valid, output packed_byte, output byte_last, output pad_bits,
                  input ready);
  modport sink   (input valid, input packed_byte, input byte_last, input pad_bits,
                  output ready);
endinterface

@@ hw/rtl/sbp_pack_core.sv @@
module sbp_pack_core (
  input  logic                       clk,
  input  logic                       rst_n,
  sbp_sym_if.sink                    in_ch,
  input  logic                       cfg_we,
  input  logic [sbp_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       room,
  output sbp_pkg::push_t             push
);

  logic [sbp_pkg::CFG_W-1:0]  sym_bits_r;
  logic [sbp_pkg::SYM_W-1:0]  sym_r;
  logic                       last_r;
  logic                       vld_r;
  logic [sbp_pkg::BYTE_W-1:0] part_r, part_nxt;
  logic [sbp_pkg::FILL_W-1:0] fill_r, fill_nxt;

  logic                       fire;
  logic [sbp_pkg::CFG_W-1:0]  n_w;
  logic [sbp_pkg::BYTE_W-1:0] mask;
  logic [sbp_pkg::BYTE_W-1:0] masked;
  logic [3:0]                 total;
  logic [4:0]                 shamt;
  logic [15:0]                win;
  logic [sbp_pkg::BYTE_W-1:0] part_a;
  logic [sbp_pkg::FILL_W-1:0] fill_a;

  assign fire        = vld_r && room;
  assign in_ch.ready = !vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_r <= sbp_pkg::SYM_BITS_RESET;
    end else if (cfg_we) begin
      sym_bits_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      vld_r <= 1'b1;
    end else if (fire) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sym_r  <= in_ch.symbol;
      last_r <= in_ch.last_symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      fill_r <= '0;
    end else if (fire) begin
      part_r <= part_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Window: current byte in [15:8], overflow into [7:0].
  always_comb begin
    n_w    = (sym_bits_r > sbp_pkg::SYM_BITS_MAX) ? sbp_pkg::SYM_BITS_MAX : sym_bits_r;
    mask   = 8'hFF >> (4'd8 - n_w);
    masked = sym_r & mask;
    total  = {1'b0, fill_r} + n_w;
    shamt  = 5'd16 - {1'b0, total};
    win    = {part_r, 8'h00} | ({8'h00, masked} << shamt);
  end

  always_comb begin
    push   = '0;
    part_a = part_r;
    fill_a = fill_r;
    if (n_w != '0) begin
      if (total >= 4'd8) begin
        push.push0             = fire;
        push.item0.packed_byte = win[15:8];
        part_a                 = win[7:0];
        fill_a                 = total[sbp_pkg::FILL_W-1:0];
      end else begin
        part_a = win[15:8];
        fill_a = total[sbp_pkg::FILL_W-1:0];
      end
    end
    part_nxt = part_a;
    fill_nxt = fill_a;
    if (last_r) begin
      if (fill_a != '0) begin
        // flush the padded partial byte behind any full byte
        if (push.push0) begin
          push.push1             = fire;
          push.item1.packed_byte = part_a;
          push.item1.byte_last   = 1'b1;
          push.item1.pad_bits    = sbp_pkg::PAD_W'(4'd8 - {1'b0, fill_a});
        end else begin
          push.push0             = fire;
          push.item0.packed_byte = part_a;
          push.item0.byte_last   = 1'b1;
          push.item0.pad_bits    = sbp_pkg::PAD_W'(4'd8 - {1'b0, fill_a});
        end
      end else if (push.push0) begin
        push.item0.byte_last = 1'b1;
      end
      part_nxt = '0;
      fill_nxt = '0;
    end
  end

endmodule

@@ hw/rtl/sbp_out_fifo.sv @@
module sbp_out_fifo #(
  parameter int DEPTH = sbp_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sbp_pkg::push_t push,
  output logic           room,
  sbp_byte_if.source     out_ch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sbp_pkg::byte_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_1;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          pop;
  logic [CW-1:0] n_push;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop      = (cnt_r != '0) && out_ch.ready;
  assign n_push   = CW'(push.push0) + CW'(push.push1);
  assign wr_ptr_1 = ptr_inc(wr_ptr_r);
  assign room     = cnt_r <= CW'(DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.push1) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_1);
    end else if (push.push0) begin
      wr_ptr_nxt = wr_ptr_1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_r + n_push - CW'(pop);
    end
  end

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.packed_byte = mem_r[rd_ptr_r].packed_byte;
  assign out_ch.byte_last   = mem_r[rd_ptr_r].byte_last;
  assign out_ch.pad_bits    = mem_r[rd_ptr_r].pad_bits;

endmodule

@@ hw/rtl/symbol_bit_packer_top.sv @@
// Flow: an accepted symbol waits in the input register until the queue has room, then
//   writes its bytes there; the head byte is offered as soon as the queue holds it.
// Throughput: one symbol per cycle while the receiver keeps up; hold the symbol in the
//   input register whenever the queue has fewer than two free slots (depth 4 by default).
// Reset: synchronous, active low; clears the partial byte, fill count and queue,
//   and sets symbol_bits to 5.
module symbol_bit_packer_top #(
  parameter int FIFO_DEPTH = sbp_pkg::FIFO_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sbp_sym_if.sink                   in_ch,
  sbp_byte_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [sbp_pkg::CFG_W-1:0] cfg_wdata
);

  // Push bundle from the packer into the queue, and the queue's room flag
  // (space for two bytes) that lets the packer consume its held item.
  sbp_pkg::push_t push;
  logic           room;

  // Hold the symbol in the input register, merge it into the partial byte,
  // and hand up to two finished bytes to the queue in the same cycle.
  sbp_pack_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .room      (room),
    .push      (push)
  );

  // Queue the bytes; the head drives the output channel directly, so a
  // stalled byte never blocks a new symbol while room remains.
  sbp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

@@ hw/rtl/sbp_checker.sv @@
module sbp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sbp_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_last,
  input logic [sbp_pkg::PAD_W-1:0]  out_pad
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_pad))
    else $error("output item changed while stalled");

  a_pad_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pad != '0) |-> out_last)
    else $error("pad bits on a byte that is not last");

  a_pad_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && (out_pad != '0)
      |-> ((out_byte & (8'hFF >> (4'd8 - {1'b0, out_pad}))) == '0))
    else $error("padding bits not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind symbol_bit_packer_top sbp_checker u_sbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.packed_byte),
  .out_last  (out_ch.byte_last),
  .out_pad   (out_ch.pad_bits)
);

@@ tb/packer_scoreboard_pkg.sv @@
`timescale 1ns / 100ps

package packer_scoreboard_pkg;
  import sbp_pkg::*;

  class packer_scoreboard;
    logic [CFG_W-1:0]  sym_bits;
    logic [BYTE_W-1:0] held_bits;    // MSB-aligned bits not yet emitted
    int unsigned       held_count;
    byte_item_t        expected_bytes[$];
    int unsigned       mismatches;
    int unsigned       symbols_seen;
    int unsigned       bytes_seen;
    int unsigned       streams_closed;

    function new();
      sym_bits       = SYM_BITS_RESET;
      held_bits      = '0;
      held_count     = 0;
      mismatches     = 0;
      symbols_seen   = 0;
      bytes_seen     = 0;
      streams_closed = 0;
    endfunction

    function void write_width(logic [CFG_W-1:0] w);
      sym_bits = w;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // Append one symbol to the bit stream and queue every byte it completes.
    function void note_symbol(logic [SYM_W-1:0] symbol, logic last_symbol);
      int unsigned width;
      int unsigned total;
      int unsigned produced;
      logic [15:0] mask;
      logic [15:0] window;
      byte_item_t  b;
      produced = 0;
      symbols_seen++;
      width = (sym_bits > SYM_BITS_MAX) ? int'(SYM_BITS_MAX) : int'(sym_bits);
      if (width > 0) begin
        total  = held_count + width;
        mask   = (16'd1 << width) - 16'd1;
        window = {held_bits, 8'h00} | ((16'(symbol) & mask) << (16 - total));
        if (total >= BYTE_W) begin
          b.packed_byte = window[15:8];
          b.byte_last   = 1'b0;
          b.pad_bits    = '0;
          expected_bytes.push_back(b);
          produced++;
          held_bits  = window[7:0];
          held_count = total - BYTE_W;
        end else begin
          held_bits  = window[15:8];
          held_count = total;
        end
      end
      if (last_symbol) begin
        if (held_count != 0) begin
          b.packed_byte = held_bits;
          b.byte_last   = 1'b1;
          b.pad_bits    = PAD_W'(BYTE_W - held_count);
          expected_bytes.push_back(b);
        end else if (produced > 0) begin
          // the byte just completed closes the stream with no padding
          expected_bytes[expected_bytes.size()-1].byte_last = 1'b1;
          expected_bytes[expected_bytes.size()-1].pad_bits  = '0;
        end
        held_bits  = '0;
        held_count = 0;
        streams_closed++;
      end
    endfunction

    function void check_byte(logic [BYTE_W-1:0] packed_byte, logic byte_last,
                             logic [PAD_W-1:0] pad_bits);
      byte_item_t want;
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: packed_byte=%0h byte_last=%0b pad_bits=%0d",
               packed_byte, byte_last, pad_bits);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (packed_byte !== want.packed_byte) begin
        $error("packed_byte: expected %0h, actual %0h", want.packed_byte, packed_byte);
        mismatches++;
      end
      if (byte_last !== want.byte_last) begin
        $error("byte_last: expected %0b, actual %0b", want.byte_last, byte_last);
        mismatches++;
      end
      if (pad_bits !== want.pad_bits) begin
        $error("pad_bits: expected %0d, actual %0d", want.pad_bits, pad_bits);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb_symbol_bit_packer_top.sv @@
`timescale 1ns / 100ps

module tb_symbol_bit_packer_top;
  import sbp_pkg::*;
  import packer_scoreboard_pkg::*;

  // Watchdog limit: abort once the run of cycles with no handshake and no register write reaches it.
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 12;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  sbp_sym_if  sym_ch ();
  sbp_byte_if byte_ch ();

  packer_scoreboard sb;

  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  // Width for each random phase: every legal width, zero width, and an
  // oversized setting that must behave as eight.
  int phase_width [PHASES] = '{1, 7, 8, 3, 0, 6, 2, 5, 4, 13, 8, 1};

  symbol_bit_packer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sym_ch),
    .out_ch    (byte_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random with the current idle share.
  always @(posedge clk) begin
    byte_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check every byte accepted on the output channel against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && byte_ch.valid === 1'b1 && byte_ch.ready) begin
      sb.check_byte(byte_ch.packed_byte, byte_ch.byte_last, byte_ch.pad_bits);
    end
  end

  // Watchdog: count cycles with no handshake and no register write.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (sym_ch.valid && sym_ch.ready) ||
        (byte_ch.valid === 1'b1 && byte_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("symbol_bit_packer_top test failed");
        $finish;
      end
    end
  end

  // Offer one symbol, idling first at random, and return at the edge that
  // accepts it. Leave valid high so a following item can go back to back.
  task automatic send_symbol(input logic [SYM_W-1:0] symbol, input logic last_symbol);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    sym_ch.valid       <= 1'b1;
    sym_ch.symbol      <= symbol;
    sym_ch.last_symbol <= last_symbol;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    sb.note_symbol(symbol, last_symbol);
  endtask

  // Drain the output, give any result-free symbol time to clear the input
  // register, then write the width. Bits already held stay in the packer.
  task automatic set_width(input logic [CFG_W-1:0] w);
    sym_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_width(w);
  endtask

  initial begin
    int n_items;
    sb                  = new();
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    sym_ch.valid        = 1'b0;
    sym_ch.symbol       = '0;
    sym_ch.last_symbol  = 1'b0;
    byte_ch.ready       = 1'b0;
    quiet_cycles        = 0;
    send_idle_pct       = 17;
    recv_idle_pct       = 60;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset width of five; upper symbol bits must be masked off.
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hEA, 1'b1);
    // Last symbol fills the byte exactly: one byte, marked, no padding.
    set_width(4'd8);
    send_symbol(8'hA5, 1'b1);
    // Last symbol spills into a second byte: full byte first, padded byte last.
    set_width(4'd3);
    send_symbol(8'h07, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h05, 1'b1);
    // Hold two bits, switch to zero width mid-stream, flush them on last.
    set_width(4'd2);
    send_symbol(8'h02, 1'b0);
    set_width(4'd0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b1);
    // Last with nothing held: no byte at all.
    send_symbol(8'h5A, 1'b1);
    // Oversized widths behave as eight.
    set_width(4'd12);
    send_symbol(8'h3C, 1'b0);
    send_symbol(8'hC3, 1'b1);
    set_width(4'd1);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h01, 1'b1);
    set_width(4'd15);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b1);

    // Random streams: switch idle pattern every four phases, change width
    // each phase, sometimes with bits still held from an open stream.
    for (int p = 0; p < PHASES; p++) begin
      case (p / 4)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_width(CFG_W'(phase_width[p]));
      n_items = (phase_width[p] == 0) ? 20 : 75;
      for (int i = 0; i < n_items; i++) begin
        send_symbol(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end
    end

    // Drop valid, wait out the last bytes, then allow for anything late.
    sym_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Packed %0d symbols into %0d bytes, %0d streams closed",
             sb.symbols_seen, sb.bytes_seen, sb.streams_closed);
    $display("Widths 0 to 8 and oversized 12/13/15, three stall patterns on both sides");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("symbol_bit_packer_top test passed");
    end else begin
      $display("symbol_bit_packer_top test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sbp_pkg.sv
hw/rtl/sbp_sym_if.sv
hw/rtl/sbp_byte_if.sv
hw/rtl/sbp_pack_core.sv
hw/rtl/sbp_out_fifo.sv
hw/rtl/symbol_bit_packer_top.sv
hw/rtl/sbp_checker.sv
tb/packer_scoreboard_pkg.sv
tb/tb_symbol_bit_packer_top.sv
